>>> src/svm_pkg.sv
// shared types and constants of the stack machine execute unit
package svm_pkg;

    // stream payload widths, packed to whole bytes
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 88;

    // opcodes
    localparam logic [5:0] OP_LEA  = 6'd0;
    localparam logic [5:0] OP_IMM  = 6'd1;
    localparam logic [5:0] OP_JMP  = 6'd2;
    localparam logic [5:0] OP_CALL = 6'd3;
    localparam logic [5:0] OP_JZ   = 6'd4;
    localparam logic [5:0] OP_JNZ  = 6'd5;
    localparam logic [5:0] OP_ENT  = 6'd6;
    localparam logic [5:0] OP_ADJ  = 6'd7;
    localparam logic [5:0] OP_LEV  = 6'd8;
    localparam logic [5:0] OP_LI   = 6'd9;
    localparam logic [5:0] OP_LC   = 6'd10;
    localparam logic [5:0] OP_SI   = 6'd11;
    localparam logic [5:0] OP_SC   = 6'd12;
    localparam logic [5:0] OP_PUSH = 6'd13;
    localparam logic [5:0] OP_OR   = 6'd14;
    localparam logic [5:0] OP_XOR  = 6'd15;
    localparam logic [5:0] OP_AND  = 6'd16;
    localparam logic [5:0] OP_EQ   = 6'd17;
    localparam logic [5:0] OP_NE   = 6'd18;
    localparam logic [5:0] OP_LT   = 6'd19;
    localparam logic [5:0] OP_GT   = 6'd20;
    localparam logic [5:0] OP_LE   = 6'd21;
    localparam logic [5:0] OP_GE   = 6'd22;
    localparam logic [5:0] OP_SHL  = 6'd23;
    localparam logic [5:0] OP_SHR  = 6'd24;
    localparam logic [5:0] OP_ADD  = 6'd25;
    localparam logic [5:0] OP_SUB  = 6'd26;
    localparam logic [5:0] OP_MUL  = 6'd27;
    localparam logic [5:0] OP_DIV  = 6'd28;
    localparam logic [5:0] OP_MOD  = 6'd29;
    localparam logic [5:0] OP_EXIT = 6'd37;

    // status codes
    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_EXIT = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_DIV0 = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_WAITA,
        S_EXEC,
        S_DIV,
        S_DIVEND,
        S_OUT
    } state_t;

endpackage

>>> src/stack_vm_execute_unit.sv
// Stack machine execute unit: one instruction per input transfer, one result per instruction.
// Steps per instruction: issue, memory read, second read or execute, then the output register;
// DIV and MOD by a nonzero value add the radix-2 divider steps and a sign fix-up step.
// One instruction at a time: the next transfer is taken only in idle, after the previous result
// is placed in the output register; memory reads share the single port of the word memory.
// Reset: after rst_n releases, a clearing pass writes zero to all MEM_WORDS words, one per
// cycle, before the first input transfer; configuration writes are taken during it.
module stack_vm_execute_unit
    import svm_pkg::*;
#(
    parameter int MEM_WORDS  = 16384,
    parameter int CODE_WORDS = 65536
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration: start_pc
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // cmd[5:0], operand[37:6]
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // next_pc[15:0], accumulator[47:16],
                                            // status[49:48], exit_value[81:50],
                                            // used_operand[82]
);

    localparam int          AW      = $clog2(MEM_WORDS);
    localparam logic [15:0] SP_INIT = 16'(MEM_WORDS % 65536);
    localparam logic [29:0] MEM_LIM = 30'(MEM_WORDS);
    localparam logic [23:0] CW24    = 24'(CODE_WORDS);
    localparam logic [16:0] CW17    = 17'(CODE_WORDS);

    // reduce a 16-bit value modulo CODE_WORDS (quotient fits in 8 bits)
    function automatic logic [15:0] code_wrap(input logic [15:0] x);
        logic [23:0] r;
        logic [23:0] d;
        r = {8'b0, x};
        for (int k = 7; k >= 0; k--)
        begin
            d = CW24 << k;
            if (r >= d)
            begin
                r = r - d;
            end
        end
        return r[15:0];
    endfunction

    // advance a code index that is already below CODE_WORDS
    function automatic logic [15:0] pc_add(input logic [15:0] p, input logic [1:0] inc);
        logic [16:0] s;
        s = {1'b0, p} + {15'b0, inc};
        if (s >= CW17)
        begin
            s = s - CW17;
        end
        return s[15:0];
    endfunction

    function automatic logic in_mem(input logic [29:0] idx);
        return idx < MEM_LIM;
    endfunction

    function automatic logic [31:0] sext8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    state_t state_reg, state_next;

    logic [5:0]  op_reg;
    logic [31:0] opd_reg;
    logic [15:0] pc_reg, sp_reg, bp_reg;
    logic [31:0] ax_reg;
    logic        halted_reg;
    logic [31:0] a_reg;
    logic        ok_reg;
    logic [AW-1:0] clr_reg;

    logic [31:0] dvd_reg, rem_reg, dsr_reg;
    logic [4:0]  cnt_reg;
    logic        neg_q_reg, neg_r_reg;

    logic [15:0] res_pc_reg;
    logic [31:0] res_ax_reg, res_exit_reg;
    logic [1:0]  res_st_reg;
    logic        res_used_reg;

    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    // ram port
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wdata, ram_rdata;
    logic          rd_ok;

    // read addresses
    logic [29:0] addr_a, addr_b;
    logic [31:0] a_val, b_val;

    // execute results
    logic [31:0] ax_n, exit_n, wr_data, a_op;
    logic [15:0] sp_n, bp_n, npc, tgt, wrap_in, sp_dec;
    logic [1:0]  st_n;
    logic        used_n, halt_n, wr_en, go_div;
    logic [29:0] wr_idx;
    logic [4:0]  sh;
    logic [31:0] byte_sel;

    // divider step
    logic [31:0] rem_sh, rem_sub;
    logic        rem_ge;
    logic [31:0] q_fix, r_fix;

    logic out_free;

    logic [5:0]  in_cmd;
    logic [31:0] in_operand;

    assign in_cmd     = s_tdata[5:0];
    assign in_operand = s_tdata[37:6];
    assign out_free   = !m_valid_reg || m_tready;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;

    svm_ram #(
        .WIDTH(32),
        .DEPTH(MEM_WORDS)
    ) u_mem (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // masked read data: out-of-range words read as zero
    assign a_val = ok_reg ? ram_rdata : 32'd0;
    assign b_val = ok_reg ? ram_rdata : 32'd0;

    // first and second read addresses
    always_comb
    begin
        addr_a = {14'b0, sp_reg};
        if (!halted_reg && op_reg == OP_LEV)
        begin
            addr_a = {14'b0, bp_reg};
        end
        else if (!halted_reg && (op_reg == OP_LI || op_reg == OP_LC))
        begin
            addr_a = ax_reg[31:2];
        end
        if (op_reg == OP_LEV)
        begin
            addr_b = {14'b0, bp_reg + 16'd1};
        end
        else
        begin
            addr_b = a_val[31:2];
        end
    end

    // execute datapath
    always_comb
    begin
        sp_dec   = sp_reg - 16'd1;
        ax_n     = ax_reg;
        sp_n     = sp_reg;
        bp_n     = bp_reg;
        npc      = pc_add(pc_reg, 2'd1);
        st_n     = ST_RUN;
        exit_n   = 32'd0;
        used_n   = 1'b0;
        halt_n   = halted_reg;
        wr_en    = 1'b0;
        wr_idx   = {14'b0, sp_dec};
        wr_data  = ax_reg;
        go_div   = 1'b0;
        a_op     = a_reg;
        sh       = {ax_reg[1:0], 3'b0};
        byte_sel = a_reg >> sh;
        wrap_in  = (op_reg == OP_LEV) ? b_val[15:0] : opd_reg[15:0];
        tgt      = code_wrap(wrap_in);
        if (halted_reg)
        begin
            st_n   = ST_EXIT;
            exit_n = a_reg;
            npc    = pc_reg;
        end
        else if (op_reg <= OP_LEV)
        begin
            used_n = 1'b1;
            npc    = pc_add(pc_reg, 2'd2);
            case (op_reg)
                OP_LEA: ax_n = {14'b0, bp_reg, 2'b0} + {opd_reg[29:0], 2'b0};
                OP_IMM: ax_n = opd_reg;
                OP_JMP: npc = tgt;
                OP_CALL:
                begin
                    wr_en   = 1'b1;
                    wr_data = {16'b0, pc_add(pc_reg, 2'd2)};
                    sp_n    = sp_dec;
                    npc     = tgt;
                end
                OP_JZ:  if (ax_reg == 32'd0) npc = tgt;
                OP_JNZ: if (ax_reg != 32'd0) npc = tgt;
                OP_ENT:
                begin
                    wr_en   = 1'b1;
                    wr_data = {14'b0, bp_reg, 2'b0};
                    bp_n    = sp_dec;
                    sp_n    = sp_dec - opd_reg[15:0];
                end
                OP_ADJ: sp_n = sp_reg + opd_reg[15:0];
                default:
                begin
                    // frame return: sp = bp, pop bp, pop pc
                    used_n = 1'b0;
                    sp_n   = bp_reg + 16'd2;
                    bp_n   = a_reg[17:2];
                    npc    = tgt;
                end
            endcase
        end
        else if (op_reg <= OP_PUSH)
        begin
            case (op_reg)
                OP_LI: ax_n = a_reg;
                OP_LC: ax_n = sext8(byte_sel[7:0]);
                OP_SI:
                begin
                    sp_n   = sp_reg + 16'd1;
                    wr_en  = 1'b1;
                    wr_idx = a_reg[31:2];
                end
                OP_SC:
                begin
                    sp_n    = sp_reg + 16'd1;
                    wr_en   = 1'b1;
                    wr_idx  = a_reg[31:2];
                    sh      = {a_reg[1:0], 3'b0};
                    wr_data = (b_val & ~(32'hFF << sh)) | ({24'b0, ax_reg[7:0]} << sh);
                    ax_n    = sext8(ax_reg[7:0]);
                end
                default:
                begin
                    wr_en = 1'b1;
                    sp_n  = sp_dec;
                end
            endcase
        end
        else if (op_reg <= OP_MOD)
        begin
            sp_n = sp_reg + 16'd1;
            case (op_reg)
                OP_OR:  ax_n = a_op | ax_reg;
                OP_XOR: ax_n = a_op ^ ax_reg;
                OP_AND: ax_n = a_op & ax_reg;
                OP_EQ:  ax_n = {31'b0, a_op == ax_reg};
                OP_NE:  ax_n = {31'b0, a_op != ax_reg};
                OP_LT:  ax_n = {31'b0, $signed(a_op) < $signed(ax_reg)};
                OP_GT:  ax_n = {31'b0, $signed(a_op) > $signed(ax_reg)};
                OP_LE:  ax_n = {31'b0, $signed(a_op) <= $signed(ax_reg)};
                OP_GE:  ax_n = {31'b0, $signed(a_op) >= $signed(ax_reg)};
                OP_SHL: ax_n = (|ax_reg[31:5]) ? 32'd0 : (a_op << ax_reg[4:0]);
                OP_SHR: ax_n = (|ax_reg[31:5]) ? {32{a_op[31]}}
                                               : 32'($signed(a_op) >>> ax_reg[4:0]);
                OP_ADD: ax_n = a_op + ax_reg;
                OP_SUB: ax_n = a_op - ax_reg;
                OP_MUL: ax_n = a_op * ax_reg;
                default:
                begin
                    if (ax_reg == 32'd0)
                    begin
                        ax_n = 32'd0;
                        st_n = ST_DIV0;
                    end
                    else
                    begin
                        go_div = 1'b1;
                    end
                end
            endcase
        end
        else if (op_reg == OP_EXIT)
        begin
            halt_n = 1'b1;
            st_n   = ST_EXIT;
            exit_n = a_reg;
            npc    = pc_reg;
        end
        else
        begin
            st_n = ST_BAD;
            npc  = pc_reg;
        end
    end

    // divider step and sign fix-up
    always_comb
    begin
        rem_sh  = {rem_reg[30:0], dvd_reg[31]};
        rem_ge  = rem_sh >= dsr_reg;
        rem_sub = rem_sh - dsr_reg;
        q_fix   = neg_q_reg ? (32'd0 - dvd_reg) : dvd_reg;
        r_fix   = neg_r_reg ? (32'd0 - rem_reg) : rem_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (clr_reg == AW'(MEM_WORDS - 1)) state_next = S_IDLE;
            S_IDLE:   if (s_tvalid) state_next = S_ISSUE;
            S_ISSUE:  state_next = S_WAITA;
            S_WAITA:  state_next = S_EXEC;
            S_EXEC:   state_next = go_div ? S_DIV : S_OUT;
            S_DIV:    if (cnt_reg == 5'd31) state_next = S_DIVEND;
            S_DIVEND: state_next = S_OUT;
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // handshake and memory port control
    always_comb
    begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = addr_a[AW-1:0];
        ram_wdata = wr_data;
        rd_ok     = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = 32'd0;
            end
            S_IDLE:  s_tready = 1'b1;
            S_ISSUE: rd_ok = in_mem(addr_a);
            S_WAITA:
            begin
                ram_addr = addr_b[AW-1:0];
                rd_ok    = in_mem(addr_b);
            end
            S_EXEC:
            begin
                ram_addr = wr_idx[AW-1:0];
                ram_we   = wr_en && in_mem(wr_idx);
            end
            default: ram_we = 1'b0;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            pc_reg      <= 16'd0;
            sp_reg      <= SP_INIT;
            bp_reg      <= SP_INIT;
            ax_reg      <= 32'd0;
            halted_reg  <= 1'b0;
            ok_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= rd_ok;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            // commit architectural registers
            if (state_reg == S_EXEC)
            begin
                pc_reg     <= npc;
                sp_reg     <= sp_n;
                bp_reg     <= bp_n;
                ax_reg     <= ax_n;
                halted_reg <= halt_n;
            end
            if (state_reg == S_DIVEND)
            begin
                ax_reg <= (op_reg == OP_DIV) ? q_fix : r_fix;
            end
            if (cfg_we)
            begin
                pc_reg <= code_wrap(cfg_data);
            end
            // output register
            if (state_reg == S_OUT && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            op_reg  <= in_cmd;
            opd_reg <= in_operand;
        end
        if (state_reg == S_WAITA)
        begin
            a_reg <= a_val;
        end
        if (state_reg == S_EXEC)
        begin
            res_pc_reg   <= npc;
            res_ax_reg   <= ax_n;
            res_st_reg   <= st_n;
            res_exit_reg <= exit_n;
            res_used_reg <= used_n;
            dvd_reg      <= a_reg[31] ? (32'd0 - a_reg) : a_reg;
            dsr_reg      <= ax_reg[31] ? (32'd0 - ax_reg) : ax_reg;
            rem_reg      <= 32'd0;
            cnt_reg      <= 5'd0;
            neg_q_reg    <= a_reg[31] ^ ax_reg[31];
            neg_r_reg    <= a_reg[31];
        end
        if (state_reg == S_DIV)
        begin
            rem_reg <= rem_ge ? rem_sub : rem_sh;
            dvd_reg <= {dvd_reg[30:0], rem_ge};
            cnt_reg <= cnt_reg + 5'd1;
        end
        if (state_reg == S_DIVEND)
        begin
            res_ax_reg <= (op_reg == OP_DIV) ? q_fix : r_fix;
        end
        if (state_reg == S_OUT && out_free)
        begin
            m_data_reg <= {5'b0, res_used_reg, res_exit_reg, res_st_reg,
                           res_ax_reg, res_pc_reg};
        end
    end

endmodule

>>> src/svm_ram.sv
// generic single-port ram with registered read
module svm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read; on a write the read returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> verif/stack_vm_execute_unit_tb.sv
// self-checking testbench for the stack machine execute unit
module stack_vm_execute_unit_tb;
    import svm_pkg::*;

    localparam int MEM_WORDS  = 16384;
    localparam int IDLE_LIMIT = 100000;

    typedef struct {
        logic [5:0]  cmd;
        logic [31:0] operand;
    } vm_instr_t;

    typedef struct packed {
        logic        used;
        logic [31:0] exit_val;
        logic [1:0]  status;
        logic [31:0] acc;
        logic [15:0] next_pc;
    } vm_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [15:0]           cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // cmd[5:0], operand[37:6]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // next_pc, accumulator, status, exit_value, used_operand

    // machine state mirrored by the predictor
    logic [15:0] mdl_pc;
    logic [15:0] mdl_sp;
    logic [15:0] mdl_bp;
    logic [31:0] mdl_ax;
    logic [31:0] mdl_mem [MEM_WORDS];
    logic        mdl_halted;

    vm_instr_t  instr_q[$];
    vm_result_t result_q[$];
    int         n_errors;
    int         idle_cycles;
    logic       in_taken;
    logic       tx_hold;
    logic       rx_hold_req;
    int         burst_left;
    int         gap_left;
    int         rx_hold_left;
    int         rx_mode;
    int         rx_mode_left;

    stack_vm_execute_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [31:0] mem_read(input logic [31:0] idx);
        return (idx < MEM_WORDS) ? mdl_mem[idx] : 32'd0;
    endfunction

    function automatic void mem_write(input logic [31:0] idx, input logic [31:0] v);
        if (idx < MEM_WORDS)
            mdl_mem[idx] = v;
    endfunction

    function automatic logic [31:0] stack_pop();
        logic [31:0] v;
        v = mem_read({16'd0, mdl_sp});
        mdl_sp = mdl_sp + 16'd1;
        return v;
    endfunction

    function automatic void stack_push(input logic [31:0] v);
        mdl_sp = mdl_sp - 16'd1;
        mem_write({16'd0, mdl_sp}, v);
    endfunction

    function automatic logic [31:0] sext_byte(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    // executes one instruction on the mirrored machine
    function automatic vm_result_t execute_instr(input vm_instr_t ins);
        vm_result_t  r;
        logic [31:0] a;
        logic [31:0] w;
        logic [4:0]  sh;
        longint      qa;
        longint      qb;
        r.next_pc  = mdl_pc + 16'd1;
        r.status   = ST_RUN;
        r.exit_val = '0;
        r.used     = 1'b0;
        if (mdl_halted)
        begin
            r.status   = ST_EXIT;
            r.exit_val = mem_read({16'd0, mdl_sp});
            r.next_pc  = mdl_pc;
        end
        else if (ins.cmd <= OP_LEV)
        begin
            r.used    = 1'b1;
            r.next_pc = mdl_pc + 16'd2;
            case (ins.cmd)
                OP_LEA:  mdl_ax = {16'd0, mdl_bp} * 4 + ins.operand * 4;
                OP_IMM:  mdl_ax = ins.operand;
                OP_JMP:  r.next_pc = ins.operand[15:0];
                OP_CALL:
                begin
                    stack_push({16'd0, mdl_pc + 16'd2});
                    r.next_pc = ins.operand[15:0];
                end
                OP_JZ:   if (mdl_ax == 0) r.next_pc = ins.operand[15:0];
                OP_JNZ:  if (mdl_ax != 0) r.next_pc = ins.operand[15:0];
                OP_ENT:
                begin
                    stack_push({16'd0, mdl_bp} * 4);
                    mdl_bp = mdl_sp;
                    mdl_sp = mdl_sp - ins.operand[15:0];
                end
                OP_ADJ:  mdl_sp = mdl_sp + ins.operand[15:0];
                default:
                begin
                    r.used = 1'b0;
                    mdl_sp = mdl_bp;
                    a = stack_pop();
                    mdl_bp = a[17:2];
                    a = stack_pop();
                    r.next_pc = a[15:0];
                end
            endcase
        end
        else if (ins.cmd <= OP_PUSH)
        begin
            case (ins.cmd)
                OP_LI: mdl_ax = mem_read(mdl_ax >> 2);
                OP_LC:
                begin
                    w = mem_read(mdl_ax >> 2) >> (mdl_ax[1:0] * 8);
                    mdl_ax = sext_byte(w[7:0]);
                end
                OP_SI:
                begin
                    a = stack_pop();
                    mem_write(a >> 2, mdl_ax);
                end
                OP_SC:
                begin
                    a = stack_pop();
                    sh = {a[1:0], 3'b000};
                    w = mem_read(a >> 2);
                    w = (w & ~(32'hFF << sh)) | ({24'd0, mdl_ax[7:0]} << sh);
                    mem_write(a >> 2, w);
                    mdl_ax = sext_byte(mdl_ax[7:0]);
                end
                default: stack_push(mdl_ax);
            endcase
        end
        else if (ins.cmd <= OP_MOD)
        begin
            a = stack_pop();
            case (ins.cmd)
                OP_OR:  mdl_ax = a | mdl_ax;
                OP_XOR: mdl_ax = a ^ mdl_ax;
                OP_AND: mdl_ax = a & mdl_ax;
                OP_EQ:  mdl_ax = (a == mdl_ax) ? 32'd1 : 32'd0;
                OP_NE:  mdl_ax = (a != mdl_ax) ? 32'd1 : 32'd0;
                OP_LT:  mdl_ax = ($signed(a) <  $signed(mdl_ax)) ? 32'd1 : 32'd0;
                OP_GT:  mdl_ax = ($signed(a) >  $signed(mdl_ax)) ? 32'd1 : 32'd0;
                OP_LE:  mdl_ax = ($signed(a) <= $signed(mdl_ax)) ? 32'd1 : 32'd0;
                OP_GE:  mdl_ax = ($signed(a) >= $signed(mdl_ax)) ? 32'd1 : 32'd0;
                OP_SHL: mdl_ax = (mdl_ax >= 32) ? 32'd0 : (a << mdl_ax[4:0]);
                OP_SHR: mdl_ax = (mdl_ax >= 32) ? {32{a[31]}}
                                                : 32'($signed(a) >>> mdl_ax[4:0]);
                OP_ADD: mdl_ax = a + mdl_ax;
                OP_SUB: mdl_ax = a - mdl_ax;
                OP_MUL: mdl_ax = a * mdl_ax;
                default:
                begin
                    if (mdl_ax == 0)
                        r.status = ST_DIV0;
                    else
                    begin
                        // 64-bit math keeps the most negative word over -1 exact
                        qa = longint'($signed(a));
                        qb = longint'($signed(mdl_ax));
                        mdl_ax = (ins.cmd == OP_DIV) ? 32'(qa / qb) : 32'(qa % qb);
                    end
                end
            endcase
        end
        else if (ins.cmd == OP_EXIT)
        begin
            mdl_halted = 1'b1;
            r.status   = ST_EXIT;
            r.exit_val = mem_read({16'd0, mdl_sp});
            r.next_pc  = mdl_pc;
        end
        else
        begin
            r.status  = ST_BAD;
            r.next_pc = mdl_pc;
        end
        mdl_pc = r.next_pc;
        r.acc  = mdl_ax;
        return r;
    endfunction

    // input side: predict on every accepted transfer
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            result_q.push_back(execute_instr(instr_q.pop_front()));
            in_taken = 1'b1;
        end
    end

    // driver: bursts with random gaps, valid held until transfer
    always @(negedge clk)
    begin
        if (!(s_tvalid && !in_taken))
        begin
            in_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (instr_q.size() > 0 && !tx_hold && rst_n)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, instr_q[0].operand, instr_q[0].cmd};
                burst_left = burst_left - 1;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: stall pattern picked at random among three modes, plus one long hold
    always @(negedge clk)
    begin
        if (rx_hold_req)
        begin
            rx_hold_req = 1'b0;
            rx_hold_left = 400;
        end
        if (rx_mode_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(20, 80);
        end
        else
            rx_mode_left = rx_mode_left - 1;
        if (rx_hold_left > 0)
        begin
            rx_hold_left = rx_hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (rx_mode == 0)
            m_tready <= 1'b1;
        else if (rx_mode == 1)
            m_tready <= $urandom_range(0, 1);
        else
            m_tready <= ($urandom_range(0, 3) == 0);
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        vm_result_t got;
        vm_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[82:0];
            if (result_q.size() == 0)
            begin
                $error("result transfer with no instruction outstanding");
                n_errors++;
            end
            else
            begin
                exp_r = result_q.pop_front();
                if (got.next_pc !== exp_r.next_pc)
                begin
                    $error("next_pc exp %h got %h", exp_r.next_pc, got.next_pc);
                    n_errors++;
                end
                if (got.acc !== exp_r.acc)
                begin
                    $error("accumulator exp %h got %h", exp_r.acc, got.acc);
                    n_errors++;
                end
                if (got.status !== exp_r.status)
                begin
                    $error("status exp %0d got %0d", exp_r.status, got.status);
                    n_errors++;
                end
                if (got.exit_val !== exp_r.exit_val)
                begin
                    $error("exit_value exp %h got %h", exp_r.exit_val, got.exit_val);
                    n_errors++;
                end
                if (got.used !== exp_r.used)
                begin
                    $error("used_operand exp %0d got %0d", exp_r.used, got.used);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("stack_vm_execute_unit verification failed");
            $finish;
        end
    end

    function automatic void add_instr(input logic [5:0] c, input logic [31:0] o);
        vm_instr_t ins;
        ins.cmd     = c;
        ins.operand = o;
        instr_q.push_back(ins);
    endfunction

    // byte address, mostly near the top of the data memory
    function automatic logic [31:0] data_addr();
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return 4 * (MEM_WORDS - $urandom_range(1, 64)) + $urandom_range(0, 3);
    endfunction

    function automatic logic [31:0] small_signed();
        return 32'($signed($urandom_range(0, 16)) - 8);
    endfunction

    // appends one short instruction sequence, returns its length
    function automatic int add_sequence();
        int          kind;
        logic [31:0] b;
        kind = $urandom_range(0, 11);
        case (kind)
            0, 1:
            begin
                add_instr(OP_IMM, data_addr());
                add_instr(OP_PUSH, $urandom);
                add_instr(OP_IMM, $urandom);
                add_instr(kind == 0 ? OP_SI : OP_SC, $urandom);
                return 4;
            end
            2:
            begin
                add_instr(OP_IMM, data_addr());
                add_instr($urandom_range(0, 1) ? OP_LI : OP_LC, $urandom);
                return 2;
            end
            3, 4, 5:
            begin
                case ($urandom_range(0, 3))
                    0: b = 32'd0;
                    1: b = $urandom_range(0, 40);
                    2: b = small_signed();
                    default: b = $urandom;
                endcase
                add_instr(OP_IMM, $urandom_range(0, 1) ? $urandom : small_signed());
                add_instr(OP_PUSH, $urandom);
                add_instr(OP_IMM, b);
                add_instr(6'($urandom_range(OP_OR, OP_MOD)), $urandom);
                return 4;
            end
            6:
            begin
                add_instr(OP_CALL, $urandom);
                add_instr(OP_ENT, $urandom_range(0, 6));
                add_instr(OP_LEA, small_signed());
                add_instr(OP_ADJ, small_signed());
                add_instr(OP_LEV, $urandom);
                return 5;
            end
            7:
            begin
                add_instr(OP_IMM, $urandom_range(0, 1) ? 32'd0 : $urandom);
                add_instr($urandom_range(0, 1) ? OP_JZ : OP_JNZ, $urandom);
                return 2;
            end
            8:
            begin
                add_instr(OP_JMP, $urandom);
                return 1;
            end
            9:
            begin
                add_instr(6'($urandom_range(30, 36)), $urandom);
                return 1;
            end
            default:
            begin
                add_instr(6'($urandom_range(0, 36)), $urandom);
                return 1;
            end
        endcase
    endfunction

    task automatic wait_drained();
        while (instr_q.size() > 0 || s_tvalid || result_q.size() > 0)
            @(posedge clk);
        // every result is back at this point; the wait that follows only adds idle time
        repeat (60) @(posedge clk);
    endtask

    task automatic write_start_pc(input logic [15:0] v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        mdl_pc = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // stimulus and end of run
    initial
    begin
        logic [15:0] start_vals [5];
        int          n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        n_errors = 0;
        idle_cycles = 0;
        in_taken = 1'b0;
        tx_hold = 1'b0;
        rx_hold_req = 1'b0;
        burst_left = 0;
        gap_left = 0;
        rx_hold_left = 0;
        rx_mode = 0;
        rx_mode_left = 0;
        mdl_pc = '0;
        mdl_sp = 16'(MEM_WORDS);
        mdl_bp = 16'(MEM_WORDS);
        mdl_ax = '0;
        mdl_halted = 1'b0;
        for (int i = 0; i < MEM_WORDS; i++)
            mdl_mem[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        start_vals[0] = 16'hFFFF;
        start_vals[1] = 16'h0000;
        start_vals[2] = 16'($urandom);
        start_vals[3] = 16'h8000;
        start_vals[4] = 16'hFFFE;

        // directed: extremes, overflowing and zero divides, shifts, frames, bytes
        write_start_pc(start_vals[0]);
        add_instr(OP_IMM, 32'h8000_0000);
        add_instr(OP_PUSH, 32'h0);
        add_instr(OP_IMM, 32'hFFFF_FFFF);
        add_instr(OP_DIV, 32'h0);
        add_instr(OP_PUSH, 32'h0);
        add_instr(OP_IMM, 32'hFFFF_FFFF);
        add_instr(OP_MOD, 32'h0);
        add_instr(OP_DIV, 32'h0);
        add_instr(OP_MOD, 32'hFFFF_FFFF);
        add_instr(OP_IMM, 32'd40);
        add_instr(OP_SHL, 32'h0);
        add_instr(OP_IMM, 32'd33);
        add_instr(OP_SHR, 32'h0);
        add_instr(OP_IMM, 4 * (MEM_WORDS - 2) + 3);
        add_instr(OP_PUSH, 32'h0);
        add_instr(OP_IMM, 32'h0000_00F0);
        add_instr(OP_SC, 32'h0);
        add_instr(OP_IMM, 4 * (MEM_WORDS - 2) + 3);
        add_instr(OP_LC, 32'h0);
        add_instr(OP_LEA, 32'h7FFF_FFFF);
        add_instr(OP_CALL, 32'hFFFF_FFFF);
        add_instr(OP_ENT, 32'h2);
        add_instr(OP_LEV, 32'h0);
        add_instr(OP_JMP, 32'h0001_0000);
        add_instr(6'd33, 32'hFFFF_FFFF);

        for (int p = 0; p < 5; p++)
        begin
            if (p > 0)
            begin
                wait_drained();
                write_start_pc(start_vals[p]);
            end
            if (p == 2)
                rx_hold_req = 1'b1;
            n = 0;
            while (n < 110)
            begin
                n += add_sequence();
                if (p == 3 && n >= 50 && n < 55)
                begin
                    // sender stops until every result is back
                    wait (instr_q.size() == 0);
                    tx_hold = 1'b1;
                    while (s_tvalid || result_q.size() > 0)
                        @(posedge clk);
                    tx_hold = 1'b0;
                end
            end
        end
        // halt, then a few instructions that must be ignored
        add_instr(OP_EXIT, $urandom);
        add_instr(OP_IMM, $urandom);
        add_instr(OP_PUSH, $urandom);
        add_instr(OP_EXIT, $urandom);

        wait_drained();
        if (n_errors == 0)
            $display("stack_vm_execute_unit verification clean");
        else
            $display("stack_vm_execute_unit verification failed");
        $finish;
    end

endmodule
